// File: hdl/least_loaded_task_dispatcher_defines.svh
// assertion helpers for the dispatcher
`ifndef LEAST_LOADED_TASK_DISPATCHER_DEFINES_SVH
`define LEAST_LOADED_TASK_DISPATCHER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LLTD_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LLTD_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lltd_pkg.sv
package lltd_pkg;

  localparam int WORKERS     = 8;
  localparam int QUEUE_DEPTH = 8;
  localparam int TASK_WIDTH  = 64;

  localparam int WID_W  = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int ADDR_W = (WORKERS * QUEUE_DEPTH > 1) ? $clog2(WORKERS * QUEUE_DEPTH) : 1;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_BAD_WORKER = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_EMPTY      = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [3:0]  target_worker;
    logic [63:0] task_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  chosen_worker;
    logic [63:0] task_out;
    logic        task_valid;
  } out_item_t;

endpackage

// File: hdl/least_loaded_task_dispatcher.sv
// channel | handshake            | payload
// input   | in_valid, in_ready   | in_data  in_item_t: mode, target_worker, task_word
// result  | out_valid, out_ready | out_data out_item_t: status, chosen_worker, task_out, task_valid
//
// one word accepted per cycle while the result side keeps up; each result is registered
// in the queue memory read stage, then in the output register
// the single-port queue memory takes one read or one write per word
// rst_n (synchronous) empties every queue: heads and fill counts cleared
// a stalled output holds the read stage, which then blocks input
`include "least_loaded_task_dispatcher_defines.svh"

module least_loaded_task_dispatcher
  import lltd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [TASK_WIDTH-1:0] task_mem [WORKERS*QUEUE_DEPTH];
  logic [TASK_WIDTH-1:0] rd_data_r;

  logic [SLOT_W-1:0] head_r [WORKERS];
  logic [CNT_W-1:0]  fill_r [WORKERS];

  // read stage
  logic       s1_v_r;
  logic [1:0] s1_status_r;
  logic [3:0] s1_worker_r;
  logic       s1_tv_r;

  // output register
  logic      out_v_r;
  out_item_t out_r;

  logic              accept;
  logic              s1_adv;
  logic [WID_W-1:0]  least_w;
  logic [WID_W-1:0]  sel_w;
  logic [CNT_W-1:0]  sel_fill;
  logic [SLOT_W-1:0] sel_head;
  logic [SUM_W-1:0]  tail_sum;
  logic [SUM_W-1:0]  head_sum;
  logic [SLOT_W-1:0] tail_slot;
  logic [SLOT_W-1:0] head_nxt;
  logic [ADDR_W-1:0] mem_addr;
  logic [WID_W:0]    worker_num;
  logic              bad_worker;
  logic              is_full;
  logic              is_empty;
  logic [1:0]        status_nxt;
  logic              do_write;
  logic              do_read;

  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || !out_v_r || out_ready;
  assign accept   = in_valid && in_ready;

  // lowest-index minimum over the fill counts
  always_comb begin
    least_w = '0;
    for (int i = 1; i < WORKERS; i++) begin
      if (fill_r[i] < fill_r[least_w]) begin
        least_w = WID_W'(i);
      end
    end
  end

  always_comb begin
    bad_worker = (int'(in_data.target_worker) > WORKERS) ||
                 (in_data.mode == MODE_DEQ && in_data.target_worker == 4'd0);
    sel_w      = (in_data.target_worker == 4'd0) ? least_w
                                                 : WID_W'(in_data.target_worker - 4'd1);
    sel_fill   = fill_r[sel_w];
    sel_head   = head_r[sel_w];
    is_full    = (sel_fill == CNT_W'(QUEUE_DEPTH));
    is_empty   = (sel_fill == '0);

    tail_sum   = SUM_W'(sel_head) + SUM_W'(sel_fill);
    tail_slot  = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                                                    : SLOT_W'(tail_sum);
    head_sum   = SUM_W'(sel_head) + SUM_W'(1);
    head_nxt   = (head_sum >= SUM_W'(QUEUE_DEPTH)) ? '0 : SLOT_W'(head_sum);

    priority if (bad_worker) begin
      status_nxt = ST_BAD_WORKER;
    end else if (in_data.mode == MODE_ENQ && is_full) begin
      status_nxt = ST_FULL;
    end else if (in_data.mode == MODE_DEQ && is_empty) begin
      status_nxt = ST_EMPTY;
    end else begin
      status_nxt = ST_DONE;
    end

    do_write   = accept && status_nxt == ST_DONE && in_data.mode == MODE_ENQ;
    do_read    = accept && status_nxt == ST_DONE && in_data.mode == MODE_DEQ;
    mem_addr   = ADDR_W'(int'(sel_w) * QUEUE_DEPTH) +
                 ADDR_W'((in_data.mode == MODE_ENQ) ? tail_slot : sel_head);
    worker_num = {1'b0, sel_w} + {{WID_W{1'b0}}, 1'b1};
  end

  // queue memory: one access per cycle, registered read
  always_ff @(posedge clk) begin
    if (do_write) begin
      task_mem[mem_addr] <= in_data.task_word[TASK_WIDTH-1:0];
    end
    if (do_read) begin
      rd_data_r <= task_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WORKERS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else if (do_write) begin
      fill_r[sel_w] <= sel_fill + CNT_W'(1);
    end else if (do_read) begin
      fill_r[sel_w] <= sel_fill - CNT_W'(1);
      head_r[sel_w] <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status_nxt;
      s1_worker_r <= (status_nxt == ST_DONE) ? 4'(worker_num) : 4'd0;
      s1_tv_r     <= do_read;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r.status        <= s1_status_r;
      out_r.chosen_worker <= s1_worker_r;
      out_r.task_out      <= s1_tv_r ? 64'(rd_data_r) : 64'd0;
      out_r.task_valid    <= s1_tv_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `LLTD_CHECK(a_task_only_on_done, out_v_r && out_r.task_valid,
              out_r.status == ST_DONE && out_r.chosen_worker != 4'd0,
              "task word delivered without a completed dequeue")
  `LLTD_CHECK(a_reject_is_clean, out_v_r && out_r.status != ST_DONE,
              out_r.chosen_worker == 4'd0 && out_r.task_out == 64'd0 && !out_r.task_valid,
              "rejected word carries a worker or task")
  `LLTD_CHECK_NEXT(a_read_stage_holds, s1_v_r && out_v_r && !out_ready,
                   s1_v_r && $stable(rd_data_r) && $stable(s1_status_r),
                   "read stage lost its word under stall")

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import lltd_pkg::*;

  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int unsigned           queue_head [WORKERS];
  int unsigned           queue_fill [WORKERS];
  logic [TASK_WIDTH-1:0] queue_store [WORKERS][QUEUE_DEPTH];

  out_item_t   pending_results [$];
  stim_row_t   dir_rows [19];
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  least_loaded_task_dispatcher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // works out the result of one word and moves the queue state on
  function automatic out_item_t dispatch_predict(in_item_t w);
    out_item_t   r;
    int unsigned q;
    int unsigned k;
    int unsigned slot;
    r = '0;
    if (w.target_worker > WORKERS || (w.mode == MODE_DEQ && w.target_worker == 0)) begin
      r.status = ST_BAD_WORKER;
      return r;
    end
    if (w.target_worker == 0) begin
      q = 0;
      for (k = 1; k < WORKERS; k++)
        if (queue_fill[k] < queue_fill[q]) q = k;
    end else begin
      q = w.target_worker - 1;
    end
    if (w.mode == MODE_ENQ) begin
      if (queue_fill[q] >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
        return r;
      end
      slot = (queue_head[q] + queue_fill[q]) % QUEUE_DEPTH;
      queue_store[q][slot] = w.task_word[TASK_WIDTH-1:0];
      queue_fill[q]++;
    end else begin
      if (queue_fill[q] == 0) begin
        r.status = ST_EMPTY;
        return r;
      end
      r.task_out   = 64'(queue_store[q][queue_head[q]]);
      r.task_valid = 1'b1;
      queue_head[q] = (queue_head[q] + 1) % QUEUE_DEPTH;
      queue_fill[q]--;
    end
    r.status        = ST_DONE;
    r.chosen_worker = 4'(q + 1);
    return r;
  endfunction

  task automatic send_word(in_item_t w, bit typed = 1'b0, out_item_t res = '0);
    out_item_t predicted;
    // steady stretch with no gaps
    if (words_sent < 100 || words_sent >= 250)
      while ($urandom_range(0, 99) < 23) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predicted = dispatch_predict(w);
    pending_results.push_back(typed ? res : predicted);
    words_sent++;
  endtask

  task automatic send_random(logic m, logic [3:0] tgt);
    in_item_t w;
    w.mode          = m;
    w.target_worker = tgt;
    w.task_word     = {$urandom, $urandom};
    send_word(w);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result word %p", $time, got);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      mismatch_count++;
    end
    if (got.chosen_worker !== want.chosen_worker) begin
      $display("%0t: chosen_worker expected %0d actual %0d", $time,
               want.chosen_worker, got.chosen_worker);
      mismatch_count++;
    end
    if (got.task_out !== want.task_out) begin
      $display("%0t: task_out expected %h actual %h", $time, want.task_out, got.task_out);
      mismatch_count++;
    end
    if (got.task_valid !== want.task_valid) begin
      $display("%0t: task_valid expected %b actual %b", $time, want.task_valid, got.task_valid);
      mismatch_count++;
    end
  endtask

  // result side: random back-pressure, a steady stretch without it, plus one long hold-off
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        check_result(out_data);
        results_seen++;
      end
      if (!held && results_seen >= 350) begin
        held      = 1'b1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (results_seen >= 100 && results_seen < 250) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 23);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned kind;
    int unsigned n;
    int unsigned k;
    int unsigned w;
    logic [3:0]  tgt;
    bit          flooded;
    bit          drained;

    words_sent     = 0;
    results_seen   = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    flooded        = 1'b0;
    drained        = 1'b0;
    for (k = 0; k < WORKERS; k++) begin
      queue_head[k] = 0;
      queue_fill[k] = 0;
    end

    dir_rows = '{
      '{'{MODE_DEQ, 4'd1, 64'd0}, 1'b1, '{ST_EMPTY, 4'd0, 64'd0, 1'b0}},
      '{'{MODE_DEQ, 4'd0, 64'd0}, 1'b1, '{ST_BAD_WORKER, 4'd0, 64'd0, 1'b0}},
      '{'{MODE_ENQ, 4'd9, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
        '{ST_BAD_WORKER, 4'd0, 64'd0, 1'b0}},
      '{'{MODE_ENQ, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
        '{ST_BAD_WORKER, 4'd0, 64'd0, 1'b0}},
      '{'{MODE_DEQ, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
        '{ST_BAD_WORKER, 4'd0, 64'd0, 1'b0}},
      '{'{MODE_ENQ, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, '{ST_DONE, 4'd1, 64'd0, 1'b0}},
      '{'{MODE_ENQ, 4'd0, 64'd0}, 1'b1, '{ST_DONE, 4'd2, 64'd0, 1'b0}},
      '{'{MODE_ENQ, 4'd8, 64'h8000_0000_0000_0001}, 1'b1, '{ST_DONE, 4'd8, 64'd0, 1'b0}},
      '{'{MODE_DEQ, 4'd1, 64'd0}, 1'b1,
        '{ST_DONE, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}},
      '{'{MODE_DEQ, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
        '{ST_DONE, 4'd8, 64'h8000_0000_0000_0001, 1'b1}},
      '{'{MODE_DEQ, 4'd8, 64'd0}, 1'b1, '{ST_EMPTY, 4'd0, 64'd0, 1'b0}},
      '{'{MODE_ENQ, 4'd0, 64'h0123_4567_89AB_CDEF}, 1'b0, '0},
      '{'{MODE_ENQ, 4'd0, 64'hDEAD_BEEF_CAFE_F00D}, 1'b0, '0},
      '{'{MODE_DEQ, 4'd2, 64'd0}, 1'b0, '0},
      '{'{MODE_DEQ, 4'd3, 64'd0}, 1'b0, '0},
      '{'{MODE_ENQ, 4'd8, 64'h5555_5555_5555_5555}, 1'b0, '0},
      '{'{MODE_ENQ, 4'd4, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, '0},
      '{'{MODE_DEQ, 4'd4, 64'd0}, 1'b0, '0},
      '{'{MODE_DEQ, 4'd7, 64'd0}, 1'b0, '0}
    };

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);

    while (words_sent < 650) begin
      if (!flooded && words_sent >= 300) begin
        // fill every queue through least-loaded picks, then empty them all
        flooded = 1'b1;
        for (k = 0; k < WORKERS * QUEUE_DEPTH + 6; k++) send_random(MODE_ENQ, 4'd0);
        for (w = 1; w <= WORKERS; w++)
          for (k = 0; k <= QUEUE_DEPTH; k++) send_random(MODE_DEQ, 4'(w));
      end else if (!drained && words_sent >= 450) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end else begin
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
          n   = $urandom_range(1, 12);
          tgt = 4'($urandom_range(0, WORKERS));
          for (k = 0; k < n; k++) send_random(MODE_ENQ, tgt);
        end else if (kind <= 6) begin
          n   = $urandom_range(1, 12);
          tgt = 4'($urandom_range(1, WORKERS));
          for (k = 0; k < n; k++) send_random(MODE_DEQ, tgt);
        end else if (kind <= 8) begin
          n = $urandom_range(1, 8);
          for (k = 0; k < n; k++)
            send_random(1'($urandom_range(0, 1)), 4'($urandom_range(0, WORKERS)));
        end else begin
          // noise across the whole worker field
          n = $urandom_range(1, 4);
          for (k = 0; k < n; k++)
            send_random(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: least_loaded_task_dispatcher.f
+incdir+hdl
hdl/lltd_pkg.sv
hdl/least_loaded_task_dispatcher.sv
sim/tb.sv
